>>> hw/rtl/bftr_pkg.sv
package bftr_pkg;

  // Default build values
  localparam int FONT_BYTES_DEF       = 16384;
  localparam int MAX_GLYPH_HEIGHT_DEF = 32;
  localparam int MAX_GLYPH_WIDTH_DEF  = 16;

  // Field widths
  localparam int FONT_ADDR_W = 14;
  localparam int CODE_W      = 8;
  localparam int OFFSET_W    = 32;
  localparam int ROW_BITS_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [4:0]  GLYPH_WIDTH_RST    = 5'd8;
  localparam logic [5:0]  GLYPH_HEIGHT_RST   = 6'd16;
  localparam logic [9:0]  GLYPH_COUNT_RST    = 10'd256;
  localparam logic [15:0] SCANLINE_BYTES_RST = 16'd4096;
  localparam logic [7:0]  TEXT_COLUMNS_RST   = 8'd90;
  localparam logic [7:0]  TEXT_ROWS_RST      = 8'd37;

  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PRINT = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_WIDTH    = 3'd0,
    CFG_GLYPH_HEIGHT   = 3'd1,
    CFG_GLYPH_COUNT    = 3'd2,
    CFG_SCANLINE_BYTES = 3'd3,
    CFG_TEXT_COLUMNS   = 3'd4,
    CFG_TEXT_ROWS      = 3'd5
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LDRED = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_BRED  = 7'b0001000,
    ST_FETCH = 7'b0010000,
    ST_BYTE  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

endpackage

>>> hw/rtl/bftr_ifs.sv
interface bftr_in_if
  import bftr_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [FONT_ADDR_W-1:0] font_address;
  logic [7:0]             font_byte;
  logic [CODE_W-1:0]      char_code;

  modport source (output valid, kind, font_address, font_byte, char_code, input ready);
  modport sink   (input valid, kind, font_address, font_byte, char_code, output ready);
endinterface

interface bftr_out_if
  import bftr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [OFFSET_W-1:0]   pixel_offset;
  logic [ROW_BITS_W-1:0] row_bits;
  logic                  last_row;

  modport source (output valid, pixel_offset, row_bits, last_row, input ready);
  modport sink   (input valid, pixel_offset, row_bits, last_row, output ready);
endinterface

>>> hw/rtl/bitmap_font_text_renderer.sv
// Bitmap font text console. Items on in_ch either load one font byte
// (kind 0, font_address/font_byte) or print one character (kind 1,
// char_code). A printed character other than newline yields one item on
// out_ch per glyph row: framebuffer byte offset, row pixels and a flag on
// the last row. Loads and newlines yield nothing. cfg_we/cfg_index/
// cfg_wdata write the geometry registers; write them only while idle.
// The block takes one item at a time; in_ch.ready is high only when idle.
// A load folds the address into the store one FONT_BYTES at a time, then
// writes the byte. A print is accepted, runs the shared 16x16 multiplier
// (glyph base, row*height*scanline, column*cell width), folds the glyph
// base into the store, then per glyph row reads one (width<=8) or two
// (width>8) font bytes and offers the row in the output register. The
// store port and the one output register set the per-row rate. While
// out_ch.ready is low the current row holds in the output register and
// the sequencer waits. Synchronous reset clears the cursor, restores
// register defaults and drops any pending output; the font store keeps
// its contents and is not cleared.
module bitmap_font_text_renderer
  import bftr_pkg::*;
#(
  parameter int FONT_BYTES       = FONT_BYTES_DEF,
  parameter int MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF,
  parameter int MAX_GLYPH_WIDTH  = MAX_GLYPH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bftr_in_if.sink               in_ch,
  bftr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(FONT_BYTES);
  // pointer wide enough for a raw load address and for the store size itself
  localparam int PW = (AW + 1 > FONT_ADDR_W + 1) ? AW + 1 : FONT_ADDR_W + 1;
  localparam int YW = $clog2(MAX_GLYPH_HEIGHT);
  localparam logic [PW-1:0] FB    = PW'(FONT_BYTES);
  localparam logic [4:0]    MAX_W = 5'(MAX_GLYPH_WIDTH);
  localparam logic [5:0]    MAX_H = 6'(MAX_GLYPH_HEIGHT);

  // geometry registers
  logic [4:0]  gw_r;
  logic [5:0]  gh_r;
  logic [9:0]  gc_r;
  logic [15:0] scan_r;
  logic [7:0]  cols_r;
  logic [7:0]  rows_r;

  // sequencer and datapath
  state_t        state_r, state_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [6:0]    glyph_r, glyph_nxt;
  logic [4:0]    w_r, w_nxt;
  logic [5:0]    h_r, h_nxt;
  logic [7:0]    col_r, col_nxt;
  logic [7:0]    row_r, row_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [31:0]   offs_r, offs_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic          k_r, k_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [15:0]   bits_r, bits_nxt;
  logic          last_r, last_nxt;
  logic          oval_r, oval_nxt;

  // font store
  logic [7:0] font_mem [FONT_BYTES];
  logic [7:0] mem_q_r;
  logic       mem_we;

  logic        accept;
  logic [7:0]  row_inc;
  logic [7:0]  row_adv;
  logic        wrap_line;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] mul_p;
  logic        bpr2;
  logic [15:0] row_val;
  logic [3:0]  row_sh;
  logic [4:0]  w_in;
  logic [5:0]  h_in;
  logic [PW-1:0] ptr_inc;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = oval_r;
  assign out_ch.pixel_offset = offs_r;
  assign out_ch.row_bits     = bits_r;
  assign out_ch.last_row     = last_r;

  // line advance: column back to 0, row steps and wraps at the row limit
  assign row_inc   = row_r + 8'd1;
  assign row_adv   = (row_inc >= rows_r) ? 8'd0 : row_inc;
  assign wrap_line = (col_r >= cols_r);

  // clamp geometry into the supported range
  assign w_in = (gw_r == 5'd0) ? 5'd1 : ((gw_r > MAX_W) ? MAX_W : gw_r);
  assign h_in = (gh_r == 6'd0) ? 6'd1 : ((gh_r > MAX_H) ? MAX_H : gh_r);

  // two bytes per glyph row once the glyph is wider than one byte
  assign bpr2 = (w_r > 5'd8);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      3'd0: begin
        mul_a = {9'd0, glyph_r};
        mul_b = {10'd0, h_r};
      end
      3'd1: begin
        mul_a = {8'd0, row_r};
        mul_b = {10'd0, h_r};
      end
      3'd2: begin
        mul_a = prod_r[15:0];
        mul_b = scan_r;
      end
      3'd3: begin
        mul_a = {8'd0, col_r};
        mul_b = {11'd0, w_r} + 16'd1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // glyph row alignment: the top w bits of the big-endian row value
  assign row_val = bpr2 ? {hi_r, mem_q_r} : {8'd0, mem_q_r};
  assign row_sh  = bpr2 ? 4'(5'd16 - w_r) : 4'(5'd8 - w_r);

  assign ptr_inc = ptr_r + PW'(1);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ptr_nxt   = ptr_r;
    byte_nxt  = byte_r;
    glyph_nxt = glyph_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    offs_nxt  = offs_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    hi_nxt    = hi_r;
    bits_nxt  = bits_r;
    last_nxt  = last_r;
    oval_nxt  = oval_r;
    mem_we    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.kind == KIND_LOAD) begin
            ptr_nxt   = PW'(in_ch.font_address);
            byte_nxt  = in_ch.font_byte;
            state_nxt = ST_LDRED;
          end else if (in_ch.char_code == CHAR_NEWLINE) begin
            col_nxt = 8'd0;
            row_nxt = row_adv;
          end else begin
            if (wrap_line) begin
              col_nxt = 8'd0;
              row_nxt = row_adv;
            end
            // negative codes and codes past the font fall back to glyph 0
            glyph_nxt = (in_ch.char_code != 8'd0 && !in_ch.char_code[7] &&
                         {2'd0, in_ch.char_code} < gc_r) ? in_ch.char_code[6:0] : 7'd0;
            w_nxt     = w_in;
            h_nxt     = h_in;
            step_nxt  = 3'd0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_LDRED: begin
        // fold the address into the store, then write
        if (ptr_r >= FB) begin
          ptr_nxt = ptr_r - FB;
        end else begin
          mem_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        prod_nxt = mul_p;
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd1: ptr_nxt = bpr2 ? PW'({prod_r[14:0], 1'b0}) : PW'(prod_r[15:0]);
          3'd3: acc_nxt = prod_r;
          3'd4: begin
            offs_nxt  = acc_r + {prod_r[29:0], 2'b00};
            y_nxt     = '0;
            k_nxt     = 1'b0;
            state_nxt = ST_BRED;
          end
          default: ;
        endcase
      end
      ST_BRED: begin
        if (ptr_r >= FB) begin
          ptr_nxt = ptr_r - FB;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // store read is issued at this edge; advance the byte pointer
        ptr_nxt   = (ptr_inc == FB) ? '0 : ptr_inc;
        state_nxt = ST_BYTE;
      end
      ST_BYTE: begin
        if (bpr2 && !k_r) begin
          hi_nxt    = mem_q_r;
          k_nxt     = 1'b1;
          state_nxt = ST_FETCH;
        end else begin
          k_nxt     = 1'b0;
          bits_nxt  = row_val >> row_sh;
          last_nxt  = ({1'b0, y_r} + 6'd1 == h_r);
          oval_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          oval_nxt = 1'b0;
          offs_nxt = offs_r + {16'd0, scan_r};
          y_nxt    = y_r + YW'(1);
          if (last_r) begin
            col_nxt   = col_r + 8'd1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      k_r     <= 1'b0;
      oval_r  <= 1'b0;
      gw_r    <= GLYPH_WIDTH_RST;
      gh_r    <= GLYPH_HEIGHT_RST;
      gc_r    <= GLYPH_COUNT_RST;
      scan_r  <= SCANLINE_BYTES_RST;
      cols_r  <= TEXT_COLUMNS_RST;
      rows_r  <= TEXT_ROWS_RST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      k_r     <= k_nxt;
      oval_r  <= oval_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLYPH_WIDTH:    gw_r   <= cfg_wdata[4:0];
          CFG_GLYPH_HEIGHT:   gh_r   <= cfg_wdata[5:0];
          CFG_GLYPH_COUNT:    gc_r   <= cfg_wdata[9:0];
          CFG_SCANLINE_BYTES: scan_r <= cfg_wdata;
          CFG_TEXT_COLUMNS:   cols_r <= cfg_wdata[7:0];
          CFG_TEXT_ROWS:      rows_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    byte_r  <= byte_nxt;
    glyph_r <= glyph_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    offs_r  <= offs_nxt;
    y_r     <= y_nxt;
    hi_r    <= hi_nxt;
    bits_r  <= bits_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[ptr_r[AW-1:0]] <= byte_r;
    end
    mem_q_r <= font_mem[ptr_r[AW-1:0]];
  end

endmodule

>>> hw/rtl/bftr_chk.sv
module bftr_chk
  import bftr_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_row
);

  // a stalled row stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output row dropped while stalled");

  // no new item while a row waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a row is pending");

  // reset drops any pending row
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a font load never yields a row next
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_LOAD |=> !out_valid)
    else $error("row emitted for a font load");

  // more rows follow a non-final row
  a_rows_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=> !in_ready)
    else $error("character ended before its last row");

endmodule

bind bitmap_font_text_renderer bftr_chk u_bftr_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_kind      (in_ch.kind),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_last_row (out_ch.last_row)
);

>>> tb/sv/bftr_glyph_row_check.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// font store, cursor and geometry, and scores every glyph row the block emits.
module bftr_glyph_row_check
  import bftr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bftr_in_if                    in_ch,
  bftr_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    rows_pending,
  output int                    fail_count
);

  typedef struct packed {
    logic [OFFSET_W-1:0]   pixel_offset;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last_row;
  } glyph_row_t;

  logic [7:0] font_copy [FONT_BYTES_DEF];
  glyph_row_t rows_due [$];

  logic [4:0]  width_reg;
  logic [5:0]  height_reg;
  logic [9:0]  count_reg;
  logic [15:0] scan_reg;
  logic [7:0]  cols_reg;
  logic [7:0]  lines_reg;
  logic [7:0]  cur_col;
  logic [7:0]  cur_line;

  initial begin
    foreach (font_copy[i]) font_copy[i] = 8'h00;
    fail_count   = 0;
    rows_pending = 0;
  end

  function automatic void next_text_line();
    cur_col  = '0;
    cur_line = cur_line + 8'd1;
    if (cur_line >= lines_reg) cur_line = '0;
  endfunction

  // Queue one expected row per glyph pixel row, top row first.
  function automatic void render_char(logic [CODE_W-1:0] code);
    int unsigned w, h, bpr, glyph, base;
    logic [31:0] offs;
    logic [31:0] bits;
    glyph_row_t  row;
    if (cur_col >= cols_reg) next_text_line();
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_GLYPH_WIDTH_DEF) w = MAX_GLYPH_WIDTH_DEF;
    h = (height_reg == 0) ? 1 : height_reg;
    if (h > MAX_GLYPH_HEIGHT_DEF) h = MAX_GLYPH_HEIGHT_DEF;
    bpr   = (w + 7) / 8;
    glyph = (code != 0 && code < 128 && code < count_reg) ? code : 0;
    base  = glyph * h * bpr;
    offs  = 32'(cur_line) * h * 32'(scan_reg) + 32'(cur_col) * (w + 1) * 4;
    for (int unsigned y = 0; y < h; y++) begin
      bits = '0;
      for (int unsigned k = 0; k < bpr; k++)
        bits = (bits << 8) | 32'(font_copy[(base + y * bpr + k) % FONT_BYTES_DEF]);
      row.pixel_offset = offs;
      row.row_bits     = 16'(bits >> (bpr * 8 - w));
      row.last_row     = (y + 1 == h);
      rows_due.push_back(row);
      offs = offs + 32'(scan_reg);
    end
    cur_col = cur_col + 8'd1;
  endfunction

  function automatic void score_row(glyph_row_t got);
    glyph_row_t want;
    if (rows_due.size() == 0) begin
      $error("glyph row with none due: pixel_offset %h row_bits %h last_row %b",
             got.pixel_offset, got.row_bits, got.last_row);
      fail_count++;
      return;
    end
    want = rows_due.pop_front();
    if (got.pixel_offset !== want.pixel_offset) begin
      $error("pixel_offset: expected %h, actual %h", want.pixel_offset, got.pixel_offset);
      fail_count++;
    end
    if (got.row_bits !== want.row_bits) begin
      $error("row_bits: expected %h, actual %h", want.row_bits, got.row_bits);
      fail_count++;
    end
    if (got.last_row !== want.last_row) begin
      $error("last_row: expected %b, actual %b", want.last_row, got.last_row);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = GLYPH_WIDTH_RST;
      height_reg = GLYPH_HEIGHT_RST;
      count_reg  = GLYPH_COUNT_RST;
      scan_reg   = SCANLINE_BYTES_RST;
      cols_reg   = TEXT_COLUMNS_RST;
      lines_reg  = TEXT_ROWS_RST;
      cur_col    = '0;
      cur_line   = '0;
      rows_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready)
        score_row({out_ch.pixel_offset, out_ch.row_bits, out_ch.last_row});
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLYPH_WIDTH:    width_reg  = cfg_wdata[4:0];
          CFG_GLYPH_HEIGHT:   height_reg = cfg_wdata[5:0];
          CFG_GLYPH_COUNT:    count_reg  = cfg_wdata[9:0];
          CFG_SCANLINE_BYTES: scan_reg   = cfg_wdata[15:0];
          CFG_TEXT_COLUMNS:   cols_reg   = cfg_wdata[7:0];
          CFG_TEXT_ROWS:      lines_reg  = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_LOAD)
          font_copy[in_ch.font_address] = in_ch.font_byte;
        else if (in_ch.char_code == CHAR_NEWLINE)
          next_text_line();
        else
          render_char(in_ch.char_code);
      end
    end
    rows_pending <= rows_due.size();
  end

endmodule

>>> tb/sv/tb_bitmap_font_text_renderer.sv
`timescale 1ns / 100ps

module tb_bitmap_font_text_renderer;
  import bftr_pkg::*;

  localparam int     CLK_HALF_NS      = 2;
  // A load must retire before any register write; give it margin.
  localparam int     SETTLE_CYCLES    = 20;
  localparam int     DRAIN_CYCLES     = 100;
  localparam int     LONG_HOLD_CYCLES = 400;
  localparam longint TIMEOUT_NS       = 10_000_000;

  // Register indexes the block does not decode; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    rows_pending;
  int                    fail_count;

  bftr_in_if  in_ch ();
  bftr_out_if out_ch ();

  bitmap_font_text_renderer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  bftr_glyph_row_check row_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .rows_pending(rows_pending),
    .fail_count  (fail_count)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Stimulus bookkeeping: which font bytes hold data, and enough of the
  // geometry to know which bytes a character will read.
  bit         font_written [FONT_BYTES_DEF];
  logic [4:0] geo_width;
  logic [5:0] geo_height;
  logic [9:0] geo_count;
  logic [7:0] recent_codes [8];
  bit         tx_gappy;
  bit         rx_gappy;

  // Bump hold_req to ask the receiver for one long hold-off.
  logic [7:0] hold_req     = '0;
  logic [7:0] rx_hold_seen = '0;
  int         rx_stall_left = 0;

  // Receiver: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin : receiver
    int pick;
    if (hold_req != rx_hold_seen) begin
      rx_hold_seen  = hold_req;
      rx_stall_left = LONG_HOLD_CYCLES;
    end
    if (rx_stall_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall_left--;
    end else if (!rx_gappy) begin
      out_ch.ready <= 1'b1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready  <= 1'b0;
        rx_stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  // Sender gap before the next item: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (!tx_gappy) return 0;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item and hold it until the block takes it. Keep valid high
  // across back-to-back items; lower it only when a gap is inserted.
  task automatic put_item(kind_t kind, logic [FONT_ADDR_W-1:0] addr,
                          logic [7:0] data, logic [CODE_W-1:0] code);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.font_address <= addr;
    in_ch.font_byte    <= data;
    in_ch.char_code    <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic load_font_byte(logic [FONT_ADDR_W-1:0] addr, logic [7:0] data);
    font_written[addr] = 1'b1;
    put_item(KIND_LOAD, addr, data, CODE_W'($urandom));
  endtask

  // Print one character. Fill any unwritten byte of the glyph it will use
  // first, so the block never reads a store entry that holds nothing.
  task automatic type_char(logic [CODE_W-1:0] code);
    int unsigned w, h, span, first;
    if (code != CHAR_NEWLINE) begin
      w = (geo_width == 0) ? 1 : geo_width;
      if (w > MAX_GLYPH_WIDTH_DEF) w = MAX_GLYPH_WIDTH_DEF;
      h = (geo_height == 0) ? 1 : geo_height;
      if (h > MAX_GLYPH_HEIGHT_DEF) h = MAX_GLYPH_HEIGHT_DEF;
      span  = h * ((w + 7) / 8);
      first = (code != 0 && code < 128 && code < geo_count) ? code * span : 0;
      for (int unsigned a = first; a < first + span; a++)
        if (!font_written[a]) load_font_byte(FONT_ADDR_W'(a), 8'($urandom));
    end
    put_item(KIND_PRINT, FONT_ADDR_W'($urandom), 8'($urandom), code);
  endtask

  // Drive one register write; the caller drops cfg_we after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GLYPH_WIDTH:  geo_width  = data[4:0];
      CFG_GLYPH_HEIGHT: geo_height = data[5:0];
      CFG_GLYPH_COUNT:  geo_count  = data[9:0];
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [15:0] width, logic [15:0] height, logic [15:0] count,
                              logic [15:0] scan, logic [15:0] cols, logic [15:0] lines);
    write_reg(CFG_GLYPH_WIDTH, width);
    write_reg(CFG_GLYPH_HEIGHT, height);
    write_reg(CFG_GLYPH_COUNT, count);
    write_reg(CFG_SCANLINE_BYTES, scan);
    write_reg(CFG_TEXT_COLUMNS, cols);
    write_reg(CFG_TEXT_ROWS, lines);
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait for every queued glyph row. Step past the current
  // edge first so the count reflects an item taken at that edge.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
  endtask

  // Drain, then let a trailing load or newline retire before touching registers.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random text: mostly printable characters (new glyphs or recently used
  // ones), plus newlines and stray font loads. Pause halfway until drained.
  task automatic run_random(int steps, int unsigned code_hi);
    int unsigned       pick;
    logic [CODE_W-1:0] code;
    for (int s = 0; s < steps; s++) begin
      if (s == steps / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 8) begin
        type_char(CHAR_NEWLINE);
      end else if (pick < 20) begin
        load_font_byte(FONT_ADDR_W'($urandom), 8'($urandom));
      end else if (pick < 50) begin
        type_char(recent_codes[$urandom_range(7)]);
      end else begin
        code = ($urandom_range(3) == 0) ? CODE_W'($urandom_range(128, 255))
                                        : CODE_W'($urandom_range(0, code_hi));
        recent_codes[$urandom_range(7)] = code;
        type_char(code);
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_LOAD;
    in_ch.font_address = '0;
    in_ch.font_byte    = '0;
    in_ch.char_code    = '0;
    out_ch.ready       = 1'b0;
    geo_width          = GLYPH_WIDTH_RST;
    geo_height         = GLYPH_HEIGHT_RST;
    geo_count          = GLYPH_COUNT_RST;
    foreach (recent_codes[i]) recent_codes[i] = '0;
    tx_gappy           = 1'b1;
    rx_gappy           = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tiny 3x2 font, five glyphs, a 2x2 text area so both the
    // line wrap and the row wrap show up within a handful of characters.
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0001);
    set_geometry(16'd3, 16'd2, 16'd5, 16'd64, 16'd2, 16'd2);
    load_font_byte(14'd0, 8'hFF);
    load_font_byte(14'd1, 8'h00);
    load_font_byte(14'd2, 8'h80);
    load_font_byte(14'd3, 8'h01);
    load_font_byte(14'd8, 8'hA5);
    load_font_byte(14'd9, 8'h5A);
    load_font_byte(14'h3FFF, 8'hC3);
    type_char(8'd0);          // code zero renders glyph 0
    type_char(8'd1);
    type_char(8'd4);          // column limit reached: wrap first
    type_char(8'd5);          // code equal to glyph count falls back to glyph 0
    type_char(8'd127);
    type_char(8'd128);        // signed characters fall back to glyph 0
    type_char(8'd255);
    type_char(CHAR_NEWLINE);
    type_char(CHAR_NEWLINE);  // second newline: from the top row down to row 1
    type_char(8'd1);
    settle();

    // Random small geometry. Hold the receiver off for a long stretch while
    // the sender keeps offering, so the block backs up and stalls its input.
    set_geometry(16'($urandom_range(1, 16)), 16'($urandom_range(1, 4)),
                 16'($urandom_range(1, 300)), 16'($urandom_range(4, 65535)),
                 16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)));
    hold_req <= hold_req + 8'd1;
    run_random(16, 255);
    settle();

    // Largest glyph and register maxima, no idling on either side. One glyph
    // only, since every code maps to glyph 0 with a count of one.
    tx_gappy = 1'b0;
    rx_gappy <= 1'b0;
    set_geometry(16'd16, 16'd32, 16'd1, 16'd65535, 16'd255, 16'd255);
    run_random(6, 255);
    settle();

    // All zero: width and height act as one, every character wraps first and
    // every line advance lands back on row 0.
    tx_gappy = 1'b1;
    rx_gappy <= 1'b1;
    set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(12, 255);
    settle();

    // Width and height above their maxima saturate.
    set_geometry(16'd31, 16'd63, 16'd0, 16'd4, 16'd1, 16'd255);
    run_random(6, 255);
    settle();

    // Two-byte rows and the full glyph count.
    set_geometry(16'd9, 16'd2, 16'd1023, 16'($urandom_range(4, 65535)), 16'd200, 16'd3);
    run_random(16, 127);
    settle();

    // One-pixel glyphs: walk the cursor far across a wide text area.
    set_geometry(16'd1, 16'd1, 16'd128, 16'd7, 16'd255, 16'd255);
    run_random(12, 255);
    settle();

    // Shrink the text area under the cursor: it now sits past both limits.
    set_geometry(16'd5, 16'd3, 16'd64, 16'd100, 16'd2, 16'd2);
    run_random(12, 63);
    settle();

    // Random registers with junk in the bits above each register's width.
    write_reg(CFG_SPARE_HI, 16'($urandom));
    write_reg(CFG_SPARE_LO, 16'($urandom));
    set_geometry({11'($urandom), 5'($urandom_range(1, 16))},
                 {10'($urandom), 6'($urandom_range(1, 4))},
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(12, 255);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule
